FILE: sv/mcds_pkg.sv
// Package for the mm:ss clock display scanner: field widths, register indexes,
// mode codes, reset values and the seven-segment and digit helpers.
// No dependencies.
package mcds_pkg;

  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned TPS_W     = 20;
  localparam int unsigned LP_W      = 22;
  localparam int unsigned HOFF_W    = 20;
  localparam int unsigned SEC_W     = 12;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_W     = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_HOLDOFF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_HOLDOFF    = 2'd3;

  localparam logic [TPS_W-1:0]  TPS_RESET   = 20'd1000000;
  localparam logic [LP_W-1:0]   LP_RESET    = 22'd2000000;
  localparam logic [HOFF_W-1:0] RHOFF_RESET = 20'd200000;
  localparam logic [HOFF_W-1:0] EHOFF_RESET = 20'd300000;

  localparam logic [MODE_W-1:0] MODE_WAIT_CODE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN_CODE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET_CODE  = 2'd2;

  localparam logic [SEC_W-1:0] SECONDS_WRAP = 12'd3600;
  localparam logic [SEG_W-1:0] DASH_PATTERN = 8'h40;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h67;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // s / 60 for s < 3840: 17477 / 2^20 is exact over that range
  function automatic logic [5:0] div60(input logic [SEC_W-1:0] s);
    logic [26:0] prod;
    prod = 27'(s) * 27'(17477);
    return prod[25:20];
  endfunction

  // x / 10 for x < 64: 13 / 2^7 is exact over that range
  function automatic logic [2:0] div10(input logic [5:0] x);
    logic [9:0] prod;
    prod = 10'(x) * 10'(13);
    return prod[9:7];
  endfunction

  // Digit at position sel of mm:ss (0 second ones .. 3 minute tens), s < 3600
  function automatic logic [3:0] digit_of(input logic [SEC_W-1:0] s,
                                          input logic [SEL_W-1:0] sel);
    logic [5:0]       mins;
    logic [SEC_W-1:0] sec12;
    logic [5:0]       secs;
    logic [2:0]       s_tens;
    logic [5:0]       s_ones;
    logic [2:0]       m_tens;
    logic [5:0]       m_ones;
    logic [3:0]       d;
    mins   = div60(s);
    sec12  = s - (12'(mins) * 12'd60);
    secs   = sec12[5:0];
    s_tens = div10(secs);
    s_ones = secs - (6'(s_tens) * 6'd10);
    m_tens = div10(mins);
    m_ones = mins - (6'(m_tens) * 6'd10);
    case (sel)
      2'd0:    d = s_ones[3:0];
      2'd1:    d = {1'b0, s_tens};
      2'd2:    d = m_ones[3:0];
      default: d = {1'b0, m_tens};
    endcase
    return d;
  endfunction

endpackage

FILE: sv/mmss_clock_display_scanner_top.sv
// Top level of the mm:ss clock display scanner: mode control, time keeping,
// hold-to-set and set logic, display stage and output register.
// Depends on mcds_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | input     | in_valid/in_ready   | elapsed_ticks, left_pressed, right_pressed
//   out     | output    | out_valid/out_ready | segments, digit_select, clock_mode
//   cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// One scan slot per cycle while the slot's sub-second ticks plus elapsed ticks stay below
// twice ticks_per_second and the output is not stalled; the result is registered in the
// display stage, then the output register. A Run slot with a larger total goes through a
// one-bit-per-cycle restoring divider; no new slot is taken until its result is loaded.
// Reset is synchronous and puts the block in Wait with the scan, time, hold and holdoff counters cleared.
// A stalled output holds its register; the display stage and the input back up behind it.
module mmss_clock_display_scanner_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mcds_pkg::ELAPSED_W-1:0]      in_elapsed_ticks,
  input  logic                                in_left_pressed,
  input  logic                                in_right_pressed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcds_pkg::SEG_W-1:0]          out_segments,
  output logic [mcds_pkg::SEL_W-1:0]          out_digit_select,
  output logic [mcds_pkg::MODE_W-1:0]         out_clock_mode,
  input  logic                                cfg_we,
  input  logic [mcds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcds_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int unsigned TOTAL_W = mcds_pkg::TPS_W + 1;
  localparam logic [4:0]  DIV_LAST = 5'(TOTAL_W - 1);

  typedef enum logic [mcds_pkg::MODE_W-1:0] {
    MODE_WAIT = mcds_pkg::MODE_WAIT_CODE,
    MODE_RUN  = mcds_pkg::MODE_RUN_CODE,
    MODE_SET  = mcds_pkg::MODE_SET_CODE
  } mode_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_t;

  typedef struct packed {
    logic [mcds_pkg::SEC_W-1:0]  value;
    logic [mcds_pkg::SEL_W-1:0]  sel;
    logic                        dash;
    logic [mcds_pkg::MODE_W-1:0] mode;
  } disp_t;

  // configuration
  logic [mcds_pkg::TPS_W-1:0]  tps_r, tps_nxt;
  logic [mcds_pkg::LP_W-1:0]   lp_r, lp_nxt;
  logic [mcds_pkg::HOFF_W-1:0] rhoff_r, rhoff_nxt;
  logic [mcds_pkg::HOFF_W-1:0] ehoff_r, ehoff_nxt;

  // clock state
  mode_t                       mode_r, mode_nxt;
  logic [mcds_pkg::SEL_W-1:0]  scan_r, scan_nxt;
  logic [mcds_pkg::TPS_W-1:0]  sub_r, sub_nxt;
  logic [mcds_pkg::SEC_W-1:0]  sec_r, sec_nxt;
  logic [mcds_pkg::SEC_W-1:0]  setv_r, setv_nxt;
  logic [mcds_pkg::LP_W-1:0]   hold_r, hold_nxt;
  logic [mcds_pkg::HOFF_W-1:0] hoff_r, hoff_nxt;

  // divider
  div_t                        div_st_r, div_st_nxt;
  logic [mcds_pkg::TPS_W-1:0]  div_rem_r, div_rem_nxt;
  logic [TOTAL_W-1:0]          div_num_r, div_num_nxt;
  logic [4:0]                  div_cnt_r, div_cnt_nxt;
  logic [mcds_pkg::SEC_W-1:0]  div_q_r, div_q_nxt;
  disp_t                       pend_r, pend_nxt;
  logic                        pend_set_r, pend_set_nxt;

  // display stage and output register
  logic                        s1_v_r, s1_v_nxt;
  disp_t                       s1_r, s1_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [mcds_pkg::SEG_W-1:0]  out_seg_r, out_seg_nxt;
  logic [mcds_pkg::SEL_W-1:0]  out_sel_r, out_sel_nxt;
  logic [mcds_pkg::MODE_W-1:0] out_mode_r, out_mode_nxt;

  logic                        accept, s1_adv, s1_free, s1_load;
  disp_t                       s1_in, disp;
  logic                        use_set, progress, slow;

  logic [mcds_pkg::TPS_W-1:0]  tps_eff;
  logic [TOTAL_W-1:0]          total, tps_ext, tps_dbl;
  logic                        one_sec, fast;
  logic [mcds_pkg::TPS_W-1:0]  sub_fast;
  logic [mcds_pkg::SEC_W-1:0]  sec_inc;
  logic [mcds_pkg::LP_W:0]     hold_sum;
  logic [mcds_pkg::LP_W-1:0]   hold_sat;
  logic                        long_done;
  logic [mcds_pkg::LP_W+1:0]   hold4, lp1, lp2, lp3;
  logic [mcds_pkg::SEL_W-1:0]  prog_sel;
  logic [mcds_pkg::HOFF_W-1:0] elapsed_ext, hoff_dec;
  logic [mcds_pkg::SEC_W-1:0]  set_plus1, set_plus60;
  logic [mcds_pkg::SEC_W:0]    set_sum60;
  logic [TOTAL_W-1:0]          trial;
  logic                        trial_ge;
  logic [mcds_pkg::TPS_W-1:0]  rem_step;
  logic [mcds_pkg::SEC_W:0]    q_dbl, sec_sum;
  logic [mcds_pkg::SEC_W-1:0]  q_step, sec_fin;

  // datapath pieces
  always_comb begin
    tps_eff  = (tps_r == '0) ? mcds_pkg::TPS_W'(1) : tps_r;
    tps_ext  = {1'b0, tps_eff};
    tps_dbl  = {tps_eff, 1'b0};
    total    = TOTAL_W'(sub_r) + TOTAL_W'(in_elapsed_ticks);
    one_sec  = total >= tps_ext;
    fast     = total < tps_dbl;
    sub_fast = one_sec ? mcds_pkg::TPS_W'(total - tps_ext) : total[mcds_pkg::TPS_W-1:0];
    sec_inc  = (sec_r == mcds_pkg::SECONDS_WRAP - 12'd1) ? '0 : sec_r + 12'd1;

    hold_sum  = (mcds_pkg::LP_W+1)'(hold_r) + (mcds_pkg::LP_W+1)'(in_elapsed_ticks);
    hold_sat  = hold_sum[mcds_pkg::LP_W] ? '1 : hold_sum[mcds_pkg::LP_W-1:0];
    long_done = hold_sat >= lp_r;
    // progress digit = hold * 4 / hold limit, below 4 since hold < limit here
    hold4 = {hold_sat, 2'b00};
    lp1   = (mcds_pkg::LP_W+2)'(lp_r);
    lp2   = {1'b0, lp_r, 1'b0};
    lp3   = lp1 + lp2;
    if (hold4 >= lp3) begin
      prog_sel = 2'd3;
    end else if (hold4 >= lp2) begin
      prog_sel = 2'd2;
    end else if (hold4 >= lp1) begin
      prog_sel = 2'd1;
    end else begin
      prog_sel = 2'd0;
    end

    elapsed_ext = mcds_pkg::HOFF_W'(in_elapsed_ticks);
    hoff_dec    = (hoff_r > elapsed_ext) ? hoff_r - elapsed_ext : '0;
    set_plus1   = (setv_r == mcds_pkg::SECONDS_WRAP - 12'd1) ? '0 : setv_r + 12'd1;
    set_sum60   = (mcds_pkg::SEC_W+1)'(setv_r) + 13'd60;
    set_plus60  = (set_sum60 >= 13'(mcds_pkg::SECONDS_WRAP))
                  ? mcds_pkg::SEC_W'(set_sum60 - 13'(mcds_pkg::SECONDS_WRAP))
                  : set_sum60[mcds_pkg::SEC_W-1:0];

    // one restoring step; the quotient is kept modulo 3600 as its bits arrive
    trial    = {div_rem_r, div_num_r[TOTAL_W-1]};
    trial_ge = trial >= tps_ext;
    rem_step = trial_ge ? mcds_pkg::TPS_W'(trial - tps_ext) : trial[mcds_pkg::TPS_W-1:0];
    q_dbl    = {div_q_r, trial_ge};
    q_step   = (q_dbl >= 13'(mcds_pkg::SECONDS_WRAP))
               ? mcds_pkg::SEC_W'(q_dbl - 13'(mcds_pkg::SECONDS_WRAP))
               : q_dbl[mcds_pkg::SEC_W-1:0];
    sec_sum  = (mcds_pkg::SEC_W+1)'(sec_r) + (mcds_pkg::SEC_W+1)'(div_q_r);
    sec_fin  = (sec_sum >= 13'(mcds_pkg::SECONDS_WRAP))
               ? mcds_pkg::SEC_W'(sec_sum - 13'(mcds_pkg::SECONDS_WRAP))
               : sec_sum[mcds_pkg::SEC_W-1:0];
  end

  // handshake
  always_comb begin
    s1_adv   = s1_v_r && (!out_valid_r || out_ready);
    s1_free  = !s1_v_r || s1_adv;
    in_ready = (div_st_r == DIV_IDLE) && s1_free;
    accept   = in_valid && in_ready;
  end

  // next state
  always_comb begin
    tps_nxt      = tps_r;
    lp_nxt       = lp_r;
    rhoff_nxt    = rhoff_r;
    ehoff_nxt    = ehoff_r;
    mode_nxt     = mode_r;
    scan_nxt     = scan_r;
    sub_nxt      = sub_r;
    sec_nxt      = sec_r;
    setv_nxt     = setv_r;
    hold_nxt     = hold_r;
    hoff_nxt     = hoff_r;
    div_st_nxt   = div_st_r;
    div_rem_nxt  = div_rem_r;
    div_num_nxt  = div_num_r;
    div_cnt_nxt  = div_cnt_r;
    div_q_nxt    = div_q_r;
    pend_nxt     = pend_r;
    pend_set_nxt = pend_set_r;
    s1_load      = 1'b0;
    s1_in        = s1_r;
    disp         = '0;
    use_set      = 1'b0;
    progress     = 1'b0;
    slow         = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        mcds_pkg::CFG_TICKS_PER_SECOND: tps_nxt   = cfg_wdata[mcds_pkg::TPS_W-1:0];
        mcds_pkg::CFG_HOLD_LIMIT:       lp_nxt    = cfg_wdata[mcds_pkg::LP_W-1:0];
        mcds_pkg::CFG_REPEAT_HOLDOFF:   rhoff_nxt = cfg_wdata[mcds_pkg::HOFF_W-1:0];
        mcds_pkg::CFG_ENTRY_HOLDOFF:    ehoff_nxt = cfg_wdata[mcds_pkg::HOFF_W-1:0];
        default: ;
      endcase
    end

    if (accept) begin
      scan_nxt = scan_r + 2'd1;
      disp.sel = scan_r;
      case (mode_r)
        MODE_RUN: begin
          if (fast) begin
            sub_nxt = sub_fast;
            sec_nxt = one_sec ? sec_inc : sec_r;
          end else begin
            slow        = 1'b1;
            div_st_nxt  = DIV_RUN;
            div_rem_nxt = '0;
            div_num_nxt = total;
            div_cnt_nxt = DIV_LAST;
            div_q_nxt   = '0;
          end
          if (in_right_pressed) begin
            if (long_done) begin
              mode_nxt = MODE_SET;
              setv_nxt = '0;
              hoff_nxt = ehoff_r;
              hold_nxt = '0;
            end else begin
              hold_nxt = hold_sat;
              progress = 1'b1;
              disp.sel = prog_sel;
            end
          end else begin
            hold_nxt = '0;
          end
        end
        MODE_SET: begin
          hoff_nxt = hoff_dec;
          if (hoff_dec == '0) begin
            if (in_left_pressed && in_right_pressed) begin
              sec_nxt  = setv_r;
              sub_nxt  = '0;
              hold_nxt = '0;
              mode_nxt = MODE_RUN;
            end else if (in_right_pressed) begin
              setv_nxt = set_plus1;
              hoff_nxt = rhoff_r;
            end else if (in_left_pressed) begin
              setv_nxt = set_plus60;
              hoff_nxt = rhoff_r;
            end
          end
        end
        default: begin
          mode_nxt = MODE_WAIT;
          if (in_left_pressed || in_right_pressed) begin
            mode_nxt = MODE_RUN;
            sec_nxt  = '0;
            sub_nxt  = '0;
            hold_nxt = '0;
          end
        end
      endcase
      use_set    = (mode_nxt == MODE_SET);
      disp.mode  = mode_nxt;
      disp.dash  = progress || (mode_nxt == MODE_WAIT);
      disp.value = use_set ? setv_nxt : sec_nxt;
      if (slow) begin
        // hold the display fields until the new seconds count is known
        pend_nxt     = disp;
        pend_set_nxt = use_set;
      end else begin
        s1_load = 1'b1;
        s1_in   = disp;
      end
    end

    case (div_st_r)
      DIV_RUN: begin
        div_rem_nxt = rem_step;
        div_num_nxt = {div_num_r[TOTAL_W-2:0], 1'b0};
        div_q_nxt   = q_step;
        if (div_cnt_r == '0) begin
          div_st_nxt = DIV_DONE;
        end else begin
          div_cnt_nxt = div_cnt_r - 5'd1;
        end
      end
      DIV_DONE: begin
        if (s1_free) begin
          sec_nxt     = sec_fin;
          sub_nxt     = div_rem_r;
          s1_load     = 1'b1;
          s1_in       = pend_r;
          s1_in.value = pend_set_r ? setv_r : sec_fin;
          div_st_nxt  = DIV_IDLE;
        end
      end
      default: ;
    endcase

    s1_nxt   = s1_load ? s1_in : s1_r;
    s1_v_nxt = s1_load || (s1_v_r && !s1_adv);
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;
    out_sel_nxt   = out_sel_r;
    out_mode_nxt  = out_mode_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_seg_nxt   = s1_r.dash ? mcds_pkg::DASH_PATTERN
                      : mcds_pkg::seg_pattern(mcds_pkg::digit_of(s1_r.value, s1_r.sel));
      out_sel_nxt   = s1_r.sel;
      out_mode_nxt  = s1_r.mode;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= mcds_pkg::TPS_RESET;
      lp_r        <= mcds_pkg::LP_RESET;
      rhoff_r     <= mcds_pkg::RHOFF_RESET;
      ehoff_r     <= mcds_pkg::EHOFF_RESET;
      mode_r      <= MODE_WAIT;
      scan_r      <= '0;
      sub_r       <= '0;
      sec_r       <= '0;
      setv_r      <= '0;
      hold_r      <= '0;
      hoff_r      <= '0;
      div_st_r    <= DIV_IDLE;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tps_r       <= tps_nxt;
      lp_r        <= lp_nxt;
      rhoff_r     <= rhoff_nxt;
      ehoff_r     <= ehoff_nxt;
      mode_r      <= mode_nxt;
      scan_r      <= scan_nxt;
      sub_r       <= sub_nxt;
      sec_r       <= sec_nxt;
      setv_r      <= setv_nxt;
      hold_r      <= hold_nxt;
      hoff_r      <= hoff_nxt;
      div_st_r    <= div_st_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    div_rem_r  <= div_rem_nxt;
    div_num_r  <= div_num_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_q_r    <= div_q_nxt;
    pend_r     <= pend_nxt;
    pend_set_r <= pend_set_nxt;
    s1_r       <= s1_nxt;
    out_seg_r  <= out_seg_nxt;
    out_sel_r  <= out_sel_nxt;
    out_mode_r <= out_mode_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_seg_r;
  assign out_digit_select = out_sel_r;
  assign out_clock_mode   = out_mode_r;

endmodule

FILE: sv/mcds_checker.sv
// Port-level assertions for the mm:ss clock display scanner output channel,
// with the bind that attaches them to the top level. Depends on mcds_pkg.
module mcds_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mcds_pkg::SEG_W-1:0]  out_segments,
  input logic [mcds_pkg::SEL_W-1:0]  out_digit_select,
  input logic [mcds_pkg::MODE_W-1:0] out_clock_mode
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // only the three defined modes are reported, and the point segment stays dark
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_segments[7] &&
                   (out_clock_mode == mcds_pkg::MODE_WAIT_CODE ||
                    out_clock_mode == mcds_pkg::MODE_RUN_CODE  ||
                    out_clock_mode == mcds_pkg::MODE_SET_CODE)))
    else $error("bad mode code or point segment lit");

  // Wait shows only dashes
  a_wait_dash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clock_mode == mcds_pkg::MODE_WAIT_CODE)
      |-> out_segments == mcds_pkg::DASH_PATTERN)
    else $error("Wait slot not showing a dash");

  // a stalled transfer holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_segments) &&
                                   $stable(out_digit_select) && $stable(out_clock_mode)))
    else $error("output changed while stalled");

endmodule

bind mmss_clock_display_scanner_top mcds_checker u_mcds_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_segments     (out_segments),
  .out_digit_select (out_digit_select),
  .out_clock_mode   (out_clock_mode)
);

FILE: sim/tb_mmss_clock_display_scanner_top.sv
// Self-checking testbench for mmss_clock_display_scanner_top: directed scan slots, then
// mode-aware random slots under several register settings, checked by a cycle-free predictor.
// Depends on mcds_pkg and the top level.
module tb_mmss_clock_display_scanner_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_STALL  = 400;
  localparam int DRAIN_WAIT  = 30;
  localparam int unsigned HOLD_CAP = 32'h3FFFFF;

  localparam logic [mcds_pkg::SEG_W-1:0] SEG_LUT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };

  typedef struct packed {
    logic [mcds_pkg::SEG_W-1:0]  segs;
    logic [mcds_pkg::SEL_W-1:0]  sel;
    logic [mcds_pkg::MODE_W-1:0] mode;
  } display_t;

  typedef struct packed {
    logic                           is_cfg;
    logic [mcds_pkg::CFG_IDX_W-1:0] idx;
    logic [mcds_pkg::CFG_W-1:0]     data;
    logic [mcds_pkg::ELAPSED_W-1:0] ticks;
    logic                           left;
    logic                           right;
    logic                           typed;
    display_t                       want;
  } dir_row_t;

  // is_cfg, index, data, ticks, left, right, typed, {segments, digit, mode}
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b0, '0, '0, 16'd0,     1'b0, 1'b0, 1'b1,
      '{mcds_pkg::DASH_PATTERN, 2'd0, mcds_pkg::MODE_WAIT_CODE}},
    '{1'b0, '0, '0, 16'hFFFF,  1'b0, 1'b0, 1'b1,
      '{mcds_pkg::DASH_PATTERN, 2'd1, mcds_pkg::MODE_WAIT_CODE}},
    '{1'b0, '0, '0, 16'd7,     1'b1, 1'b0, 1'b1,
      '{8'h3F, 2'd2, mcds_pkg::MODE_RUN_CODE}},
    '{1'b0, '0, '0, 16'hFFFF,  1'b0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'hFFFF,  1'b0, 1'b1, 1'b0, '0},
    '{1'b1, mcds_pkg::CFG_TICKS_PER_SECOND, 22'd10, '0, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, mcds_pkg::CFG_HOLD_LIMIT,       22'd40, '0, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, mcds_pkg::CFG_REPEAT_HOLDOFF,   22'd5,  '0, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, mcds_pkg::CFG_ENTRY_HOLDOFF,    22'd8,  '0, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'hFFFF,  1'b0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'd0,     1'b0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'd9,     1'b0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'd1,     1'b0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'd20,    1'b0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'd10,    1'b0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'd0,     1'b0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'd39,    1'b0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'd1,     1'b0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'd3,     1'b0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'd5,     1'b0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'hFFFF,  1'b1, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 16'hFFFF,  1'b1, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'd0,     1'b1, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'd40,    1'b0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 16'hFFFF,  1'b0, 1'b1, 1'b0, '0}
  };

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [mcds_pkg::ELAPSED_W-1:0] in_elapsed_ticks = '0;
  logic                           in_left_pressed = 1'b0;
  logic                           in_right_pressed = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mcds_pkg::SEG_W-1:0]     out_segments;
  logic [mcds_pkg::SEL_W-1:0]     out_digit_select;
  logic [mcds_pkg::MODE_W-1:0]    out_clock_mode;
  logic                           cfg_we = 1'b0;
  logic [mcds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcds_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // predictor state and register copies
  logic [mcds_pkg::MODE_W-1:0] clk_mode = mcds_pkg::MODE_WAIT_CODE;
  logic [mcds_pkg::SEL_W-1:0]  scan_pos = '0;
  int unsigned       frac_ticks = 0;
  int unsigned       secs_now = 0;
  int unsigned       secs_set = 0;
  int unsigned       hold_acc = 0;
  int unsigned       holdoff_cnt = 0;
  int unsigned       tps_reg = 32'(mcds_pkg::TPS_RESET);
  int unsigned       hold_limit_reg = 32'(mcds_pkg::LP_RESET);
  int unsigned       repeat_hoff_reg = 32'(mcds_pkg::RHOFF_RESET);
  int unsigned       entry_hoff_reg = 32'(mcds_pkg::EHOFF_RESET);

  display_t expected_displays [$];
  int       err_cnt = 0;
  int       results_seen = 0;
  int       cycle_cnt = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       long_stall_req = 1'b0;
  bit       long_stall_taken = 1'b0;
  int       stall_left = 0;
  bit       right_held = 1'b0;

  mmss_clock_display_scanner_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_elapsed_ticks (in_elapsed_ticks),
    .in_left_pressed  (in_left_pressed),
    .in_right_pressed (in_right_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_select (out_digit_select),
    .out_clock_mode   (out_clock_mode),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic display_t predict_display(input logic [mcds_pkg::ELAPSED_W-1:0] ticks,
                                               input logic left, input logic right);
    longint unsigned tps;
    longint unsigned total;
    longint unsigned whole;
    longint unsigned sum;
    longint unsigned frac;
    logic [mcds_pkg::SEL_W-1:0] sel;
    bit               progress;
    int unsigned      shown;
    int unsigned      dig;
    display_t         d;
    sel = scan_pos;
    progress = 1'b0;
    case (clk_mode)
      mcds_pkg::MODE_RUN_CODE: begin
        tps = (tps_reg == 0) ? 1 : tps_reg;
        total = longint'(frac_ticks) + ticks;
        whole = total / tps;
        frac_ticks = int'(total % tps);
        secs_now = int'((secs_now + whole % mcds_pkg::SECONDS_WRAP) % mcds_pkg::SECONDS_WRAP);
        if (right) begin
          sum = longint'(hold_acc) + ticks;
          hold_acc = (sum > HOLD_CAP) ? HOLD_CAP : int'(sum);
          if (hold_acc >= hold_limit_reg) begin
            clk_mode = mcds_pkg::MODE_SET_CODE;
            secs_set = 0;
            holdoff_cnt = entry_hoff_reg;
            hold_acc = 0;
          end else begin
            frac = (longint'(hold_acc) * 4) / hold_limit_reg;
            sel = (frac > 3) ? 2'd3 : mcds_pkg::SEL_W'(frac);
            progress = 1'b1;
          end
        end else begin
          hold_acc = 0;
        end
      end
      mcds_pkg::MODE_SET_CODE: begin
        holdoff_cnt = (holdoff_cnt > ticks) ? holdoff_cnt - ticks : 0;
        if (holdoff_cnt == 0) begin
          if (left && right) begin
            secs_now = secs_set % mcds_pkg::SECONDS_WRAP;
            frac_ticks = 0;
            hold_acc = 0;
            clk_mode = mcds_pkg::MODE_RUN_CODE;
          end else if (right) begin
            secs_set = (secs_set + 1) % mcds_pkg::SECONDS_WRAP;
            holdoff_cnt = repeat_hoff_reg;
          end else if (left) begin
            secs_set = (secs_set + 60) % mcds_pkg::SECONDS_WRAP;
            holdoff_cnt = repeat_hoff_reg;
          end
        end
      end
      default: begin
        // the unused code falls back to Wait
        clk_mode = mcds_pkg::MODE_WAIT_CODE;
        if (left || right) begin
          clk_mode = mcds_pkg::MODE_RUN_CODE;
          secs_now = 0;
          frac_ticks = 0;
          hold_acc = 0;
        end
      end
    endcase
    if (clk_mode == mcds_pkg::MODE_WAIT_CODE || progress) begin
      d.segs = mcds_pkg::DASH_PATTERN;
    end else begin
      shown = (clk_mode == mcds_pkg::MODE_RUN_CODE) ? secs_now : secs_set;
      case (sel)
        2'd0:    dig = shown % 10;
        2'd1:    dig = (shown / 10) % 6;
        2'd2:    dig = (shown / 60) % 10;
        default: dig = (shown / 600) % 6;
      endcase
      d.segs = SEG_LUT[4'(dig)];
    end
    d.sel = sel;
    d.mode = clk_mode;
    scan_pos = scan_pos + 1'b1;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("MISMATCH %s at result %0d: expected 0x%0h, got 0x%0h",
             what, results_seen, want_v, got_v);
    err_cnt++;
  endtask

  task automatic send_slot(input logic [mcds_pkg::ELAPSED_W-1:0] ticks, input logic left,
                           input logic right, input logic typed, input display_t want);
    display_t pred;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_elapsed_ticks <= ticks;
    in_left_pressed <= left;
    in_right_pressed <= right;
    do @(posedge clk); while (!in_ready);
    pred = predict_display(ticks, left, right);
    expected_displays.push_back(typed ? want : pred);
  endtask

  // drop valid and let every pending result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mcds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcds_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mcds_pkg::CFG_TICKS_PER_SECOND: tps_reg = 32'(data[mcds_pkg::TPS_W-1:0]);
      mcds_pkg::CFG_HOLD_LIMIT:       hold_limit_reg = 32'(data[mcds_pkg::LP_W-1:0]);
      mcds_pkg::CFG_REPEAT_HOLDOFF:   repeat_hoff_reg = 32'(data[mcds_pkg::HOFF_W-1:0]);
      mcds_pkg::CFG_ENTRY_HOLDOFF:    entry_hoff_reg = 32'(data[mcds_pkg::HOFF_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [mcds_pkg::LP_W-1:0] tps,
                           input logic [mcds_pkg::LP_W-1:0] lp,
                           input logic [mcds_pkg::LP_W-1:0] rh,
                           input logic [mcds_pkg::LP_W-1:0] eh,
                           input int n_slots, input int unsigned tick_max,
                           input int both_pct, input int release_pct, input bit squeeze);
    logic [mcds_pkg::ELAPSED_W-1:0] ticks;
    logic                 left;
    logic                 right;
    int                   roll;
    settle();
    // junk in the bits above a 20-bit register must be masked off
    write_reg(mcds_pkg::CFG_TICKS_PER_SECOND, {2'($urandom), tps[mcds_pkg::TPS_W-1:0]});
    write_reg(mcds_pkg::CFG_HOLD_LIMIT, lp);
    write_reg(mcds_pkg::CFG_REPEAT_HOLDOFF, {2'($urandom), rh[mcds_pkg::HOFF_W-1:0]});
    write_reg(mcds_pkg::CFG_ENTRY_HOLDOFF, {2'($urandom), eh[mcds_pkg::HOFF_W-1:0]});
    if (squeeze) long_stall_req = 1'b1;
    right_held = 1'b0;
    for (int k = 0; k < n_slots; k++) begin
      case ($urandom_range(0, 9))
        0:       ticks = '0;
        1:       ticks = '1;
        2, 3:    ticks = mcds_pkg::ELAPSED_W'($urandom);
        default: ticks = mcds_pkg::ELAPSED_W'($urandom_range(0, tick_max));
      endcase
      left = 1'b0;
      right = 1'b0;
      case (clk_mode)
        mcds_pkg::MODE_RUN_CODE: begin
          // hold right across slots so the hold limit can be reached
          if (right_held) begin
            if ($urandom_range(0, 99) < release_pct) right_held = 1'b0;
          end else if ($urandom_range(0, 3) == 0) begin
            right_held = 1'b1;
          end
          right = right_held || ($urandom_range(0, 7) == 0);
          left = ($urandom_range(0, 4) == 0);
        end
        mcds_pkg::MODE_SET_CODE: begin
          right_held = 1'b0;
          roll = $urandom_range(0, 99);
          if (roll < both_pct) begin
            left = 1'b1;
            right = 1'b1;
          end else if (roll < both_pct + 60) begin
            left = 1'b1;
          end else if (roll < both_pct + 85) begin
            right = 1'b1;
          end
        end
        default: begin
          left = ($urandom_range(0, 3) == 0);
          right = ($urandom_range(0, 3) == 0);
        end
      endcase
      send_slot(ticks, left, right, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_stall_req && !long_stall_taken) begin
      out_ready <= 1'b0;
      stall_left <= LONG_STALL;
      long_stall_taken <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    display_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_displays.size() == 0) begin
        report_mismatch("unexpected result", 0, 32'({out_segments, out_digit_select,
                                                      out_clock_mode}));
      end else begin
        want = expected_displays.pop_front();
        if (out_segments !== want.segs)
          report_mismatch("segments", 32'(want.segs), 32'(out_segments));
        if (out_digit_select !== want.sel)
          report_mismatch("digit_select", 32'(want.sel), 32'(out_digit_select));
        if (out_clock_mode !== want.mode)
          report_mismatch("clock_mode", 32'(want.mode), 32'(out_clock_mode));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results pending",
               cycle_cnt, expected_displays.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 52;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        settle();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
      end else begin
        send_slot(DIR_TAB[i].ticks, DIR_TAB[i].left, DIR_TAB[i].right,
                  DIR_TAB[i].typed, DIR_TAB[i].want);
      end
    end

    run_phase(22'd50, 22'd300, 22'd20, 22'd40, 200, 100, 5, 5, 1'b0);
    run_phase(22'd1, 22'd1, 22'd0, 22'd0, 150, 3, 8, 10, 1'b0);

    send_idle_pct = 52;
    recv_idle_pct = 13;
    // zero ticks per second counts as one; a zero hold limit enters Set at once
    run_phase(22'd0, 22'd0, 22'd3, 22'd2, 150, 8, 10, 10, 1'b0);
    run_phase(22'hFFFFF, 22'h3FFFFF, 22'hFFFFF, 22'hFFFFF, 250, 65535, 5, 0, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(22'd1000000, 22'd2000000, 22'd200000, 22'd300000, 150, 65535, 5, 1, 1'b1);
    // left-heavy Set sessions so the set value wraps past 59:59
    run_phase(22'd7, 22'd25, 22'd2, 22'd5, 200, 40, 1, 3, 1'b0);

    settle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
